### rtl/pspa_pkg.sv
// Package: constants and types shared by the paged slot pool allocator files.
`timescale 1ns / 1ps
package pspa_pkg;

	localparam int SLOTS_PER_PAGE = 256;
	localparam int MAX_PAGES      = 16;
	localparam int STACK_SIZE     = 4096;

	localparam int SLOT_W   = 12;
	localparam int COUNT_W  = 13;
	localparam int PAGE_OFF_W = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;

	localparam int CAPACITY_INT = (MAX_PAGES * SLOTS_PER_PAGE > STACK_SIZE) ?
		STACK_SIZE : MAX_PAGES * SLOTS_PER_PAGE;
	localparam logic [COUNT_W-1:0] CAPACITY   = COUNT_W'(CAPACITY_INT);
	localparam logic [COUNT_W-1:0] STACK_FULL = COUNT_W'(STACK_SIZE);
	localparam logic [PAGE_OFF_W-1:0] PAGE_OFF_LAST = PAGE_OFF_W'(SLOTS_PER_PAGE - 1);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_FREE_NONE = 2'd2
	} status_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

endpackage

### rtl/pspa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pspa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/paged_slot_pool_allocator.sv
// Top level: paged slot pool allocator with a LIFO free stack held in RAM.
// Output: results are registered; an allocate served from the stack reads the stack RAM
// first and registers the reused slot from S_POP.
// Throughput: one item per cycle for fresh allocates, frees and errors while the output
// is not stalled; an allocate served from the stack holds the input stalled during S_POP.
// Reset: arst_n clears counters, FSM and output valid; stack RAM contents stay undefined.
`timescale 1ns / 1ps
module paged_slot_pool_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [pspa_pkg::SLOT_W-1:0]   slot_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pspa_pkg::SLOT_W-1:0]   slot_out,
	output logic                          page_added,
	output logic                          pool_released,
	output pspa_pkg::status_t             status,
	output logic [pspa_pkg::COUNT_W-1:0]  used_after
);

	import pspa_pkg::*;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]    depth_q, depth_d;
	logic [COUNT_W-1:0]    fresh_q, fresh_d;
	logic [COUNT_W-1:0]    used_q, used_d;
	logic [PAGE_OFF_W-1:0] page_off_q, page_off_d;

	logic out_valid_q;
	logic load_out;
	logic [SLOT_W-1:0]  slot_d;
	logic               page_added_d;
	logic               released_d;
	status_t            status_d;

	logic accept;
	logic ram_we, ram_re;
	logic [SLOT_W-1:0] ram_waddr, ram_raddr, ram_rdata;

	assign in_stall = !((state_q == S_IDLE) && (!out_valid_q || !out_stall));
	assign accept   = in_valid && !in_stall;

	pspa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(STACK_SIZE)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(slot_in),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d      = state_q;
		depth_d      = depth_q;
		fresh_d      = fresh_q;
		used_d       = used_q;
		page_off_d   = page_off_q;
		load_out     = 1'b0;
		slot_d       = '0;
		page_added_d = 1'b0;
		released_d   = 1'b0;
		status_d     = ST_OK;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_waddr    = depth_q[SLOT_W-1:0];
		ram_raddr    = 12'(depth_q - 13'd1);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kind == KIND_ALLOC) begin
						if (depth_q != '0) begin
							ram_re  = 1'b1;
							depth_d = depth_q - 13'd1;
							used_d  = used_q + 13'd1;
							state_d = S_POP;
						end else if (fresh_q >= CAPACITY) begin
							load_out = 1'b1;
							status_d = ST_POOL_FULL;
						end else begin
							load_out     = 1'b1;
							slot_d       = fresh_q[SLOT_W-1:0];
							page_added_d = (page_off_q == '0);
							fresh_d      = fresh_q + 13'd1;
							page_off_d   = (page_off_q == PAGE_OFF_LAST) ? '0 :
								page_off_q + PAGE_OFF_W'(1);
							used_d       = used_q + 13'd1;
						end
					end else begin
						load_out = 1'b1;
						if (used_q == '0) begin
							status_d = ST_FREE_NONE;
						end else begin
							if (depth_q < STACK_FULL) begin
								ram_we  = 1'b1;
								depth_d = depth_q + 13'd1;
							end
							used_d = used_q - 13'd1;
							if (used_q == 13'd1) begin
								depth_d    = '0;
								fresh_d    = '0;
								page_off_d = '0;
								released_d = 1'b1;
							end
						end
					end
				end
			end
			S_POP: begin
				load_out = 1'b1;
				slot_d   = ram_rdata;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			depth_q    <= '0;
			fresh_q    <= '0;
			used_q     <= '0;
			page_off_q <= '0;
		end else begin
			state_q    <= state_d;
			depth_q    <= depth_d;
			fresh_q    <= fresh_d;
			used_q     <= used_d;
			page_off_q <= page_off_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			slot_out      <= slot_d;
			page_added    <= page_added_d;
			pool_released <= released_d;
			status        <= status_d;
			used_after    <= used_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/pspa_checker.sv
// Checker: port-level assertions for the paged slot pool allocator, with bind.
`timescale 1ns / 1ps
module pspa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pspa_pkg::SLOT_W-1:0]   slot_out,
	input logic                          page_added,
	input logic                          pool_released,
	input pspa_pkg::status_t             status,
	input logic [pspa_pkg::COUNT_W-1:0]  used_after
);

	import pspa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_out) && $stable(status)
			&& $stable(used_after))
		else $error("output item changed while stalled");

	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output blocked");

	a_release_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pool_released |-> used_after == '0 && status == ST_OK && !page_added)
		else $error("release with slots still in use");

	a_error_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> slot_out == '0 && !page_added && !pool_released)
		else $error("error item carries a slot");

endmodule

bind paged_slot_pool_allocator pspa_checker u_pspa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.slot_out     (slot_out),
	.page_added   (page_added),
	.pool_released(pool_released),
	.status       (status),
	.used_after   (used_after)
);
